@@ src/twsm_pkg.sv @@
package twsm_pkg;

	// Sequencer steps; codes above PH_RA_LO are never produced and read as idle
	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_RST_PRE = 5'd1,
		PH_RST_HI  = 5'd2,
		PH_RST_LO  = 5'd3,
		PH_ST0     = 5'd4,
		PH_ST1     = 5'd5,
		PH_ST2     = 5'd6,
		PH_ST3     = 5'd7,
		PH_ST4     = 5'd8,
		PH_ST5     = 5'd9,
		PH_ST6     = 5'd10,
		PH_WR_LO   = 5'd11,
		PH_WR_HI   = 5'd12,
		PH_WA_REL  = 5'd13,
		PH_WA_HI   = 5'd14,
		PH_WA_LO   = 5'd15,
		PH_WAIT    = 5'd16,
		PH_RD_HI   = 5'd17,
		PH_RD_LO   = 5'd18,
		PH_RA_SET  = 5'd19,
		PH_RA_HI   = 5'd20,
		PH_RA_LO   = 5'd21
	} phase_t;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_MEAS  = 2'd1,
		FUNC_RESET = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_TEMP_CMD  = 2'd0,
		REG_HUMID_CMD = 2'd1,
		REG_WAIT_LIM  = 2'd2,
		REG_PHASE_TCK = 2'd3
	} cfg_reg_t;

	localparam int WAIT_COUNT_BITS_DEF = 16;

	localparam logic [7:0]  TEMP_CMD_RST  = 8'd3;
	localparam logic [7:0]  HUMID_CMD_RST = 8'd5;
	localparam logic [15:0] WAIT_LIM_RST  = 16'hFFFF;
	localparam logic [7:0]  PHASE_TCK_RST = 8'd1;

	localparam logic [3:0] RST_CLOCKS = 4'd9;
	localparam logic [3:0] BYTE_BITS  = 4'd8;
	localparam logic [1:0] BYTE_CSUM  = 2'd2;
	localparam logic [1:0] BYTE_RSTMK = 2'd3;

endpackage

@@ src/two_wire_sensor_measure_master.sv @@
// Two-wire sensor master: one input beat is one bit-timing tick, one result beat per tick.
// Path: a beat taken is registered at the input stage, then stepped through the sequencer
// and registered on the result port once that port is empty or its beat is taken.
// Throughput: one beat per cycle unless the result side stalls; one state update per tick.
// Reset (arst_n low, asynchronous): sequencer idle, counters and internal result fields zero,
// result valid low, registers back to command 3/5, wait limit 65535, one tick per step.
module two_wire_sensor_measure_master
	import twsm_pkg::*;
#(
	parameter int WAIT_COUNT_BITS = WAIT_COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// tick channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic        mode,
	input  logic        sda_in,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        sck_level,
	output logic        sda_drive_low,
	output logic        busy_res,
	output logic        done_res,
	output logic [15:0] measured_value,
	output logic [7:0]  checksum,
	output logic [1:0]  error_count,
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// compare width for the wait counter against the 16-bit limit
	localparam int CW = (WAIT_COUNT_BITS > 16) ? WAIT_COUNT_BITS : 16;
	localparam logic [WAIT_COUNT_BITS-1:0] WAIT_MAX = '1;

	// ---------------- configuration registers ----------------
	logic [7:0]  temp_cmd_q;
	logic [7:0]  humid_cmd_q;
	logic [15:0] wait_lim_q;
	logic [7:0]  phase_tck_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cmd_q  <= TEMP_CMD_RST;
			humid_cmd_q <= HUMID_CMD_RST;
			wait_lim_q  <= WAIT_LIM_RST;
			phase_tck_q <= PHASE_TCK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_TEMP_CMD:  temp_cmd_q  <= cfg_data[7:0];
				REG_HUMID_CMD: humid_cmd_q <= cfg_data[7:0];
				REG_WAIT_LIM:  wait_lim_q  <= cfg_data;
				REG_PHASE_TCK: phase_tck_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ---------------- input stage ----------------
	logic       valid_s1;
	logic [1:0] func_s1;
	logic       mode_s1;
	logic       sda_s1;
	logic       step;   // the tick held in stage 1 is applied this cycle

	assign step     = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			mode_s1 <= mode;
			sda_s1  <= sda_in;
		end
	end

	// ---------------- sequencer state ----------------
	phase_t                     phase_q, phase_d;
	logic [3:0]                 bit_q, bit_d;
	logic [1:0]                 byte_q, byte_d;
	logic [7:0]                 shift_q, shift_d;
	logic [15:0]                value_q, value_d;
	logic [7:0]                 csum_q, csum_d;
	logic [1:0]                 err_q, err_d;
	logic [WAIT_COUNT_BITS-1:0] wait_q, wait_d;
	logic [7:0]                 timer_q, timer_d;
	logic                       done_d;

	logic [7:0]                 hold;
	logic [15:0]                limit;
	logic [7:0]                 timer_inc;
	logic [3:0]                 bit_inc;
	logic [WAIT_COUNT_BITS-1:0] wait_inc;
	logic                       wait_out;
	logic [1:0]                 err_inc;

	// zero hold and zero limit behave as one
	assign hold      = (phase_tck_q == 8'd0) ? 8'd1 : phase_tck_q;
	assign limit     = (wait_lim_q == 16'd0) ? 16'd1 : wait_lim_q;
	assign timer_inc = timer_q + 8'd1;
	assign bit_inc   = bit_q + 4'd1;
	assign wait_inc  = (wait_q == WAIT_MAX) ? wait_q : wait_q + 1'b1;
	assign wait_out  = (CW'(wait_inc) >= CW'(limit)) || (wait_inc == WAIT_MAX);

	// next state
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		byte_d  = byte_q;
		shift_d = shift_q;
		value_d = value_q;
		csum_d  = csum_q;
		err_d   = err_q;
		wait_d  = wait_q;
		timer_d = timer_q;
		done_d  = 1'b0;
		err_inc = (err_q == 2'd3) ? err_q : err_q + 2'd1;

		if (phase_q == PH_IDLE || phase_q > PH_RA_LO) begin
			phase_d = PH_IDLE;
			timer_d = 8'd0;
			case (func_t'(func_s1))
				FUNC_MEAS: begin
					shift_d = mode_s1 ? humid_cmd_q : temp_cmd_q;
					err_d   = 2'd0;
					byte_d  = 2'd0;
					bit_d   = 4'd0;
					phase_d = PH_ST0;
				end
				FUNC_RESET: begin
					// byte index three marks a connection reset: no done pulse
					byte_d  = BYTE_RSTMK;
					bit_d   = 4'd0;
					phase_d = PH_RST_PRE;
				end
				default: ;
			endcase
		end else if (phase_q == PH_WAIT) begin
			// sensor pulls data low when the conversion is ready
			if (sda_s1) begin
				wait_d = wait_inc;
				if (wait_out) begin
					err_d = err_inc;
				end
			end
			if (!sda_s1 || wait_out) begin
				phase_d = PH_RD_HI;
				timer_d = 8'd0;
				bit_d   = 4'd0;
				byte_d  = 2'd0;
				shift_d = 8'd0;
			end
		end else begin
			timer_d = timer_inc;
			if (timer_inc >= hold) begin
				done_d  = (phase_q == PH_RA_LO) && (byte_q >= BYTE_CSUM);
				timer_d = 8'd0;
				case (phase_q)
					PH_RST_PRE: phase_d = PH_RST_HI;
					PH_RST_HI:  phase_d = PH_RST_LO;
					PH_RST_LO: begin
						bit_d   = bit_inc;
						phase_d = (bit_inc >= RST_CLOCKS) ? PH_ST0 : PH_RST_HI;
					end
					PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5: begin
						phase_d = phase_t'(phase_q + 5'd1);
					end
					PH_ST6: begin
						bit_d   = 4'd0;
						phase_d = (byte_q == BYTE_RSTMK) ? PH_IDLE : PH_WR_LO;
					end
					PH_WR_LO: phase_d = PH_WR_HI;
					PH_WR_HI: begin
						shift_d = {shift_q[6:0], 1'b0};
						bit_d   = bit_inc;
						phase_d = (bit_inc >= BYTE_BITS) ? PH_WA_REL : PH_WR_LO;
					end
					PH_WA_REL: phase_d = PH_WA_HI;
					PH_WA_HI: begin
						if (sda_s1) begin
							err_d = err_inc;
						end
						phase_d = PH_WA_LO;
					end
					PH_WA_LO: begin
						wait_d  = '0;
						phase_d = PH_WAIT;
					end
					PH_RD_HI: begin
						shift_d = {shift_q[6:0], sda_s1};
						phase_d = PH_RD_LO;
					end
					PH_RD_LO: begin
						bit_d = bit_inc;
						if (bit_inc >= BYTE_BITS) begin
							case (byte_q)
								2'd0:    value_d[15:8] = shift_q;
								2'd1:    value_d[7:0]  = shift_q;
								default: csum_d        = shift_q;
							endcase
							phase_d = PH_RA_SET;
						end else begin
							phase_d = PH_RD_HI;
						end
					end
					PH_RA_SET: phase_d = PH_RA_HI;
					PH_RA_HI:  phase_d = PH_RA_LO;
					PH_RA_LO: begin
						if (byte_q >= BYTE_CSUM) begin
							phase_d = PH_IDLE;
						end else begin
							byte_d  = byte_q + 2'd1;
							bit_d   = 4'd0;
							shift_d = 8'd0;
							phase_d = PH_RD_HI;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// line levels follow the updated step
	logic sck_d;
	logic sda_low_d;

	always_comb begin
		case (phase_d)
			PH_RST_HI, PH_ST1, PH_ST2, PH_ST4, PH_ST5,
			PH_WR_HI, PH_WA_HI, PH_RD_HI, PH_RA_HI: sck_d = 1'b1;
			default:                                  sck_d = 1'b0;
		endcase
		case (phase_d)
			PH_ST2, PH_ST3, PH_ST4:          sda_low_d = 1'b1;
			PH_WR_LO, PH_WR_HI:              sda_low_d = !shift_d[7];
			PH_RA_SET, PH_RA_HI, PH_RA_LO:   sda_low_d = (byte_d < BYTE_CSUM);
			default:                         sda_low_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= 4'd0;
			byte_q  <= 2'd0;
			shift_q <= 8'd0;
			value_q <= 16'd0;
			csum_q  <= 8'd0;
			err_q   <= 2'd0;
			wait_q  <= '0;
			timer_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			shift_q <= shift_d;
			value_q <= value_d;
			csum_q  <= csum_d;
			err_q   <= err_d;
			wait_q  <= wait_d;
			timer_q <= timer_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			sck_level      <= sck_d;
			sda_drive_low  <= sda_low_d;
			busy_res       <= (phase_d != PH_IDLE);
			done_res       <= done_d;
			measured_value <= value_d;
			checksum       <= csum_d;
			error_count    <= err_d;
		end
	end

endmodule

@@ sim/two_wire_sensor_measure_master_tb.sv @@
`timescale 1ns / 1ps

module two_wire_sensor_measure_master_tb
	import twsm_pkg::*;
();

	// A beat that gets no handshake on any channel for this long means a hang
	localparam int WDOG_LIMIT = 4000;
	// Beats of real work (busy or command) the random part aims for
	localparam int RANDOM_BEATS = 80;
	localparam int PHASE_BEATS = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic        mode;
	logic        sda_in;
	logic        out_valid;
	logic        out_ready;
	logic        sck_level;
	logic        sda_drive_low;
	logic        busy_res;
	logic        done_res;
	logic [15:0] measured_value;
	logic [7:0]  checksum;
	logic [1:0]  error_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// One result beat as the block should show it
	typedef struct {
		logic        sck;
		logic        sda_low;
		logic        busy;
		logic        done;
		logic [15:0] value;
		logic [7:0]  csum;
		logic [1:0]  errs;
	} line_state_t;

	line_state_t line_states_due[$];

	// Shadow registers
	logic [7:0]  cfg_temp_cmd;
	logic [7:0]  cfg_humid_cmd;
	logic [15:0] cfg_wait_limit;
	logic [7:0]  cfg_phase_ticks;

	// Shadow sequencer
	phase_t      sq_phase;
	logic [3:0]  bit_idx;
	logic [1:0]  byte_idx;
	logic [7:0]  shreg;
	logic [15:0] val_sh;
	logic [7:0]  csum_sh;
	logic [1:0]  errs_sh;
	logic [15:0] wcnt;
	logic [7:0]  sq_timer;

	// Sensor behavior for the sequence in flight
	bit ack_missing;
	int reply_delay;
	int read_fill;      // 0 random bits, 1 all zeros, 2 all ones
	bit busy_noise;     // random commands while busy

	// Pacing of both sides: 0 none, 1 light, 2 heavy
	int tx_pace;
	int rx_pace;

	int fail_cnt;
	int shown_cnt;
	int checked_cnt;
	int work_beats;
	int meas_cnt;
	int link_reset_cnt;
	int nack_cnt;
	int timeout_cnt;
	int quiet_cycles;

	two_wire_sensor_measure_master DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.mode           (mode),
		.sda_in         (sda_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sck_level      (sck_level),
		.sda_drive_low  (sda_drive_low),
		.busy_res       (busy_res),
		.done_res       (done_res),
		.measured_value (measured_value),
		.checksum       (checksum),
		.error_count    (error_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Gap length: mostly none or short, now and then a long one
	function automatic int pick_gap(input int pace);
		int r;
		if (pace == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < ((pace == 1) ? 70 : 40))
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Advance the shadow sequencer by one tick and return the line state after it
	function automatic line_state_t step_sequencer(input func_t f, input logic m,
			input logic sda);
		line_state_t r;
		logic [7:0]  hold;
		logic [15:0] lim;
		logic        fin;
		logic        leave;
		phase_t      nxt;
		hold = (cfg_phase_ticks != 8'd0) ? cfg_phase_ticks : 8'd1;
		lim = (cfg_wait_limit != 16'd0) ? cfg_wait_limit : 16'd1;
		fin = 1'b0;
		if (sq_phase == PH_IDLE) begin
			sq_timer = '0;
			if (f == FUNC_MEAS) begin
				shreg = m ? cfg_humid_cmd : cfg_temp_cmd;
				errs_sh = '0;
				byte_idx = '0;
				bit_idx = '0;
				sq_phase = PH_ST0;
				meas_cnt++;
			end else if (f == FUNC_RESET) begin
				// reset marker: the start pattern ends back in idle
				byte_idx = BYTE_RSTMK;
				bit_idx = '0;
				sq_phase = PH_RST_PRE;
				link_reset_cnt++;
			end
		end else if (sq_phase == PH_WAIT) begin
			// sensor pulls data low when the conversion is done
			leave = 1'b0;
			if (!sda) begin
				leave = 1'b1;
			end else begin
				if (wcnt != 16'hFFFF)
					wcnt = wcnt + 16'd1;
				if (wcnt >= lim || wcnt == 16'hFFFF) begin
					if (errs_sh != 2'd3)
						errs_sh = errs_sh + 2'd1;
					timeout_cnt++;
					leave = 1'b1;
				end
			end
			if (leave) begin
				sq_phase = PH_RD_HI;
				sq_timer = '0;
				bit_idx = '0;
				byte_idx = '0;
				shreg = '0;
			end
		end else begin
			sq_timer = sq_timer + 8'd1;
			if (sq_timer >= hold) begin
				fin = (sq_phase == PH_RA_LO) && (byte_idx >= BYTE_CSUM);
				nxt = PH_IDLE;
				case (sq_phase)
					PH_RST_PRE: nxt = PH_RST_HI;
					PH_RST_HI:  nxt = PH_RST_LO;
					PH_RST_LO: begin
						bit_idx = bit_idx + 4'd1;
						nxt = (bit_idx >= RST_CLOCKS) ? PH_ST0 : PH_RST_HI;
					end
					PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5:
						nxt = phase_t'(sq_phase + 5'd1);
					PH_ST6: begin
						bit_idx = '0;
						nxt = (byte_idx == BYTE_RSTMK) ? PH_IDLE : PH_WR_LO;
					end
					PH_WR_LO:  nxt = PH_WR_HI;
					PH_WR_HI: begin
						shreg = {shreg[6:0], 1'b0};
						bit_idx = bit_idx + 4'd1;
						nxt = (bit_idx >= BYTE_BITS) ? PH_WA_REL : PH_WR_LO;
					end
					PH_WA_REL: nxt = PH_WA_HI;
					PH_WA_HI: begin
						if (sda) begin
							if (errs_sh != 2'd3)
								errs_sh = errs_sh + 2'd1;
							nack_cnt++;
						end
						nxt = PH_WA_LO;
					end
					PH_WA_LO: begin
						wcnt = '0;
						nxt = PH_WAIT;
					end
					PH_RD_HI: begin
						shreg = {shreg[6:0], sda};
						nxt = PH_RD_LO;
					end
					PH_RD_LO: begin
						bit_idx = bit_idx + 4'd1;
						if (bit_idx >= BYTE_BITS) begin
							if (byte_idx == 2'd0)
								val_sh[15:8] = shreg;
							else if (byte_idx == 2'd1)
								val_sh[7:0] = shreg;
							else
								csum_sh = shreg;
							nxt = PH_RA_SET;
						end else begin
							nxt = PH_RD_HI;
						end
					end
					PH_RA_SET: nxt = PH_RA_HI;
					PH_RA_HI:  nxt = PH_RA_LO;
					PH_RA_LO: begin
						if (byte_idx < BYTE_CSUM) begin
							byte_idx = byte_idx + 2'd1;
							bit_idx = '0;
							shreg = '0;
							nxt = PH_RD_HI;
						end
					end
					default: nxt = PH_IDLE;
				endcase
				sq_phase = nxt;
				sq_timer = '0;
			end
		end
		r.sck = sq_phase inside {PH_RST_HI, PH_ST1, PH_ST2, PH_ST4, PH_ST5, PH_WR_HI,
			PH_WA_HI, PH_RD_HI, PH_RA_HI};
		case (sq_phase)
			PH_ST2, PH_ST3, PH_ST4:         r.sda_low = 1'b1;
			PH_WR_LO, PH_WR_HI:             r.sda_low = ~shreg[7];
			PH_RA_SET, PH_RA_HI, PH_RA_LO:  r.sda_low = (byte_idx < BYTE_CSUM);
			default:                        r.sda_low = 1'b0;
		endcase
		r.busy = (sq_phase != PH_IDLE);
		r.done = fin;
		r.value = val_sh;
		r.csum = csum_sh;
		r.errs = errs_sh;
		return r;
	endfunction

	// Send one tick beat. The data line level comes from a simple sensor model
	// driven by the shadow phase: ack, conversion delay, then the read bytes.
	task automatic tick(input func_t f, input logic m);
		logic sda;
		int   gap;
		case (sq_phase)
			PH_WA_HI: sda = ack_missing;
			PH_WAIT: begin
				if (reply_delay > 0) begin
					sda = 1'b1;
					reply_delay--;
				end else begin
					sda = 1'b0;
				end
			end
			PH_RD_HI: sda = (read_fill == 0) ? 1'($urandom_range(0, 1)) : (read_fill == 2);
			default:  sda = 1'($urandom_range(0, 1));
		endcase
		gap = pick_gap(tx_pace);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		mode = m;
		sda_in = sda;
		do @(posedge clk); while (!in_ready);
		if (sq_phase != PH_IDLE || f == FUNC_MEAS || f == FUNC_RESET)
			work_beats++;
		line_states_due.push_back(step_sequencer(f, m, sda));
	endtask

	// Tick until the shadow sequencer is back in idle
	task automatic finish_sequence();
		while (sq_phase != PH_IDLE)
			tick(busy_noise ? func_t'($urandom_range(0, 3)) : FUNC_TICK,
				1'($urandom_range(0, 1)));
	endtask

	task automatic measure(input logic m, input bit nack, input int delay, input int fill);
		ack_missing = nack;
		reply_delay = delay;
		read_fill = fill;
		tick(FUNC_MEAS, m);
		finish_sequence();
	endtask

	task automatic link_reset();
		tick(FUNC_RESET, 1'($urandom_range(0, 1)));
		finish_sequence();
	endtask

	// Register write: only with the block idle and every result drained
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
		finish_sequence();
		@(negedge clk);
		in_valid = 1'b0;
		while (line_states_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TEMP_CMD:  cfg_temp_cmd = data[7:0];
			REG_HUMID_CMD: cfg_humid_cmd = data[7:0];
			REG_WAIT_LIM:  cfg_wait_limit = data;
			REG_PHASE_TCK: cfg_phase_ticks = data[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result side: random back-pressure at the falling edge
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			n = pick_gap(rx_pace);
			if (n > 0) begin
				out_ready = 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Compare each result beat against the oldest prediction
	always @(posedge clk) begin
		line_state_t e;
		if (arst_n && out_valid && out_ready) begin
			if (line_states_due.size() == 0) begin
				fail_cnt++;
				if (shown_cnt < 10) begin
					shown_cnt++;
					$display("%0t: result beat with nothing predicted", $realtime);
				end
			end else begin
				e = line_states_due.pop_front();
				checked_cnt++;
				if (sck_level !== e.sck || sda_drive_low !== e.sda_low ||
						busy_res !== e.busy || done_res !== e.done ||
						measured_value !== e.value || checksum !== e.csum ||
						error_count !== e.errs) begin
					fail_cnt++;
					if (shown_cnt < 10) begin
						shown_cnt++;
						$display("%0t: mismatch exp sck=%b sdl=%b busy=%b done=%b val=%h cs=%h err=%0d",
							$realtime, e.sck, e.sda_low, e.busy, e.done, e.value, e.csum, e.errs);
						$display("%0t:          got sck=%b sdl=%b busy=%b done=%b val=%h cs=%h err=%0d",
							$realtime, sck_level, sda_drive_low, busy_res, done_res,
							measured_value, checksum, error_count);
					end
				end
			end
		end
	end

	// Hang detector: no handshake on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("timeout: no beat for %0d cycles", WDOG_LIMIT);
			$display("[two_wire_sensor_measure_master] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// Idle ticks: plain, the unused func code, both modes, random data levels
	task automatic test_idle_ticks();
		tick(FUNC_TICK, 1'b0);
		tick(FUNC_NONE, 1'b1);
		tick(FUNC_TICK, 1'b1);
		tick(FUNC_NONE, 1'b0);
	endtask

	// Out-of-reset registers: one temperature run with the full wait limit
	task automatic test_default_measurements();
		measure(1'b0, 1'b0, 5, 0);
	endtask

	// Connection reset, then one with commands thrown at the busy sequencer
	task automatic test_connection_reset();
		link_reset();
		busy_noise = 1'b1;
		link_reset();
		busy_noise = 1'b0;
	endtask

	// Missing ack, wait timeout, and a zero wait limit (acts as one)
	task automatic test_error_paths();
		write_reg(REG_WAIT_LIM, 16'd0);
		measure(1'b1, 1'b1, 5, 0);       // both errors
		link_reset();                    // must keep the error count
		write_reg(REG_WAIT_LIM, 16'd1);
		measure(1'b0, 1'b0, 0, 1);       // new measurement clears it
	endtask

	// Command and timing registers at their extremes, read bytes all 0 / all 1
	task automatic test_register_extremes();
		write_reg(REG_TEMP_CMD, 16'hFF00);
		write_reg(REG_HUMID_CMD, 16'h00FF);
		write_reg(REG_WAIT_LIM, 16'd20);
		write_reg(REG_PHASE_TCK, 16'hFF00);   // zero ticks: held as one
		measure(1'b1, 1'b0, 2, 2);
		write_reg(REG_PHASE_TCK, 16'd2);
		measure(1'b0, 1'b0, 3, 1);
		write_reg(REG_PHASE_TCK, 16'd1);
	endtask

	// Config phases with random settings, mostly well-formed measurements
	task automatic test_random_traffic();
		int   start;
		int   phase_start;
		int   lim;
		int   r;
		logic m;
		start = work_beats;
		while (work_beats - start < RANDOM_BEATS) begin
			// settings for this phase, extremes now and then
			write_reg(REG_TEMP_CMD, 16'($urandom_range(0, 65535)));
			write_reg(REG_HUMID_CMD, 16'($urandom_range(0, 65535)));
			r = $urandom_range(0, 9);
			write_reg(REG_WAIT_LIM, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
				16'($urandom_range(1, 30)));
			r = $urandom_range(0, 9);
			write_reg(REG_PHASE_TCK, (r == 0) ? 16'h0000 : (r < 8) ? 16'h0001 :
				16'($urandom_range(2, 3)) | 16'($urandom_range(0, 255) << 8));
			lim = (cfg_wait_limit == 16'd0) ? 1 : cfg_wait_limit;
			tx_pace = $urandom_range(0, 2);
			rx_pace = $urandom_range(0, 2);
			busy_noise = ($urandom_range(0, 3) == 0);
			phase_start = work_beats;
			while (work_beats - phase_start < PHASE_BEATS) begin
				r = $urandom_range(0, 99);
				m = 1'($urandom_range(0, 1));
				if (r < 75) begin
					// timeouts only with a short limit
					if (lim <= 30 && $urandom_range(0, 4) == 0)
						measure(m, ($urandom_range(0, 7) == 0), lim + $urandom_range(0, 3),
							$urandom_range(0, 2));
					else
						measure(m, ($urandom_range(0, 7) == 0),
							$urandom_range(0, (lim > 20) ? 20 : lim - 1), $urandom_range(0, 2));
				end else if (r < 87) begin
					link_reset();
				end else begin
					repeat ($urandom_range(1, 4))
						tick(($urandom_range(0, 1) == 0) ? FUNC_TICK : FUNC_NONE, m);
				end
			end
		end
		busy_noise = 1'b0;
	endtask

	// ---------------------------------------------------------------- main

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_TICK;
		mode = 1'b0;
		sda_in = 1'b1;
		cfg_valid = 1'b0;
		cfg_index = REG_TEMP_CMD;
		cfg_data = '0;

		cfg_temp_cmd = TEMP_CMD_RST;
		cfg_humid_cmd = HUMID_CMD_RST;
		cfg_wait_limit = WAIT_LIM_RST;
		cfg_phase_ticks = PHASE_TCK_RST;
		sq_phase = PH_IDLE;
		bit_idx = '0;
		byte_idx = '0;
		shreg = '0;
		val_sh = '0;
		csum_sh = '0;
		errs_sh = '0;
		wcnt = '0;
		sq_timer = '0;
		ack_missing = 1'b0;
		reply_delay = 0;
		read_fill = 0;
		busy_noise = 1'b0;
		tx_pace = 1;
		rx_pace = 1;
		fail_cnt = 0;
		shown_cnt = 0;
		checked_cnt = 0;
		work_beats = 0;
		meas_cnt = 0;
		link_reset_cnt = 0;
		nack_cnt = 0;
		timeout_cnt = 0;
		quiet_cycles = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_ticks();
		test_default_measurements();
		test_connection_reset();
		test_error_paths();
		test_register_extremes();
		tx_pace = 1;
		rx_pace = 2;
		test_random_traffic();

		// drain, then let the pipeline run on idle before the summary
		@(negedge clk);
		in_valid = 1'b0;
		while (line_states_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d measurements, %0d connection resets, %0d missed acks, %0d wait timeouts",
			meas_cnt, link_reset_cnt, nack_cnt, timeout_cnt);
		$display("%0d result beats checked, %0d failures", checked_cnt, fail_cnt);
		if (fail_cnt == 0) begin
			$display("[two_wire_sensor_measure_master] OK");
		end else begin
			$display("[two_wire_sensor_measure_master] ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/twsm_pkg.sv
src/two_wire_sensor_measure_master.sv
sim/two_wire_sensor_measure_master_tb.sv
